// ----- rtl/core/interval_booking_conflict_table_macros.svh -----
// Assertion macros for the interval booking conflict table checker.
// Every macro samples on clk and is switched off while rst is high.
`ifndef INTERVAL_BOOKING_CONFLICT_TABLE_MACROS_SVH
`define INTERVAL_BOOKING_CONFLICT_TABLE_MACROS_SVH

// Same-cycle implication.
`define IBCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ibct check failed");

// Next-cycle implication.
`define IBCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ibct check failed");

`endif

// ----- rtl/core/ibct_pkg.sv -----
// Shared types and constants for the interval booking conflict table.
// No dependencies.
package ibct_pkg;

  localparam int TIME_W        = 32;
  localparam int RES_W         = 3;
  localparam int ENTRIES_DFLT  = 64;

  typedef struct packed {
    logic [RES_W-1:0]  res;
    logic [TIME_W-1:0] start_t;
    logic [TIME_W-1:0] end_t;
  } entry_t;

  typedef enum logic [1:0] {
    STAT_STORED    = 2'd0,
    STAT_BAD_ORDER = 2'd1,
    STAT_OVERLAP   = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_DECIDE = 1'b1
  } state_t;

endpackage

// ----- rtl/core/ibct_cell.sv -----
// One slot of the reservation chain: holds an interval, flags a clash.
// Depends on ibct_pkg.
module ibct_cell (
  input  logic            clk,
  input  logic            shift,
  input  logic            capture,
  input  logic            occupied,
  input  ibct_pkg::entry_t prev_entry,
  input  ibct_pkg::entry_t req,
  output ibct_pkg::entry_t entry,
  output logic            hit
);
  import ibct_pkg::*;

  logic clash;

  // Half-open overlap on the same resource
  assign clash = occupied && (entry.res == req.res) &&
                 (req.start_t < entry.end_t) && (req.end_t > entry.start_t);

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= prev_entry;
    end
    if (capture) begin
      hit <= clash;
    end
  end

endmodule

// ----- rtl/core/ibct_chain.sv -----
// Row of ibct_cell slots; new entries enter at slot 0 and ripple along.
// Depends on ibct_pkg and ibct_cell.
module ibct_chain #(
  parameter int ENTRIES = ibct_pkg::ENTRIES_DFLT,
  parameter int CW      = $clog2(ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             shift,
  input  logic             capture,
  input  logic [CW-1:0]    fill_count,
  input  ibct_pkg::entry_t req,
  input  ibct_pkg::entry_t new_entry,
  output logic             any_hit
);
  import ibct_pkg::*;

  entry_t             links [ENTRIES+1];
  logic [ENTRIES-1:0] hits;

  assign links[0] = new_entry;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ibct_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .capture    (capture),
      .occupied   (fill_count > CW'(i)),
      .prev_entry (links[i]),
      .req        (req),
      .entry      (links[i+1]),
      .hit        (hits[i])
    );
  end

  assign any_hit = |hits;

endmodule

// ----- rtl/core/interval_booking_conflict_table.sv -----
// Top level of the interval booking conflict table: handshake, control, status.
// Depends on ibct_pkg, ibct_chain and ibct_cell.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  request | in_valid, in_ready, req_type, resource_id,     | in
//          | start_time, end_time                           |
//  result  | out_valid, out_ready, status                   | out
//
// On the accepting edge every cell compares its interval with the request
//   ports and registers a clash flag; in the decide state the flags are
//   OR-ed and the status decided; once the previous result is taken it is
//   registered and, if stored, the chain shifts the new interval into slot 0.
// Reset clears the fill count, the state and out_valid; slot contents are
//   left as they are and only slots below the fill count take part.
// A result waiting in the output register does not block the next transfer
//   in; only a second result with the first still untaken holds the block.
module interval_booking_conflict_table #(
  parameter int ENTRIES = ibct_pkg::ENTRIES_DFLT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic [ibct_pkg::RES_W-1:0]  resource_id,
  input  logic [ibct_pkg::TIME_W-1:0] start_time,
  input  logic [ibct_pkg::TIME_W-1:0] end_time,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status
);
  import ibct_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  state_t        state, state_next;
  logic [CW-1:0] fill_count, fill_count_next;
  logic          out_valid_next;
  status_t       status_reg, status_calc;
  entry_t        in_entry;
  entry_t        req;        // held request
  logic          book;       // held req_type
  logic          any_hit;
  logic          accept;
  logic          commit;     // decision may leave this cycle
  logic          shift;

  assign in_entry = '{res: resource_id, start_t: start_time, end_t: end_time};
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign status   = status_reg;

  // Request copy for the decide cycle and for the shift into slot 0
  always_ff @(posedge clk) begin
    if (accept) begin
      req  <= in_entry;
      book <= req_type;
    end
  end

  ibct_chain #(.ENTRIES(ENTRIES), .CW(CW)) u_chain (
    .clk        (clk),
    .shift      (shift),
    .capture    (accept),
    .fill_count (fill_count),
    .req        (in_entry),
    .new_entry  (req),
    .any_hit    (any_hit)
  );

  // Priority: ordering check, then clash, then capacity
  always_comb begin
    if (book && (req.end_t <= req.start_t)) begin
      status_calc = STAT_BAD_ORDER;
    end else if (book && any_hit) begin
      status_calc = STAT_OVERLAP;
    end else if (fill_count == CW'(ENTRIES)) begin
      status_calc = STAT_FULL;
    end else begin
      status_calc = STAT_STORED;
    end
  end

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    out_valid_next  = out_valid && !out_ready;
    commit          = 1'b0;
    shift           = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // Hold here while the previous result is still untaken
        if (!out_valid || out_ready) begin
          commit         = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
          if (status_calc == STAT_STORED) begin
            shift           = 1'b1;
            fill_count_next = fill_count + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status_reg <= status_calc;
    end
  end

endmodule

// ----- rtl/core/ibct_checker.sv -----
// Port-level checks for the interval booking conflict table, with bind.
// Depends on ibct_pkg and interval_booking_conflict_table_macros.svh.
`include "interval_booking_conflict_table_macros.svh"

module ibct_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        req_type,
  input logic [ibct_pkg::RES_W-1:0]  resource_id,
  input logic [ibct_pkg::TIME_W-1:0] start_time,
  input logic [ibct_pkg::TIME_W-1:0] end_time,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  status
);
  import ibct_pkg::*;

  logic [RES_W+2*TIME_W:0] in_payload;

  assign in_payload = {req_type, resource_id, start_time, end_time};

  // One request in flight: no transfer in on the cycle after one
  `IBCT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // A fresh result only ever follows a transfer in, by way of the decide state
  `IBCT_ASSERT_NOW(a_result_has_cause, $rose(out_valid), $past(in_valid && in_ready, 2))

  // No result shows without a request behind it
  `IBCT_ASSERT_NEXT(a_idle_no_result, !out_valid && in_ready && !in_valid, !out_valid)

  // A stalled result stays put
  `IBCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))

  // A waiting request stays put
  `IBCT_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_payload))

endmodule

bind interval_booking_conflict_table ibct_checker u_ibct_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .req_type    (req_type),
  .resource_id (resource_id),
  .start_time  (start_time),
  .end_time    (end_time),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status)
);

// ----- tb/tb_interval_booking_conflict_table.sv -----
// Self-checking testbench for interval_booking_conflict_table: a directed table of requests,
// then random bookings and loads, each status compared with an in-bench reservation table or a written-in status.
// Depends on ibct_pkg and the RTL of the block.
module tb_interval_booking_conflict_table;
  timeunit 1ns;
  timeprecision 1ps;

  import ibct_pkg::*;

  localparam int   SLOTS        = ENTRIES_DFLT;
  localparam int   RANDOM_REQS  = 1450;
  localparam int   STALL_LIMIT  = 1000;  // cycles with no transfer on either side
  localparam int   DRAIN_CYCLES = 10;
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_BOOK     = 1'b1;

  // One directed request. Where 'typed' is set the status is written in by hand,
  // otherwise the in-bench table decides it.
  typedef struct packed {
    logic              kind;
    logic [RES_W-1:0]  res;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
    bit                typed;
    status_t           want;
  } req_row_t;

  localparam int DIRECTED_REQS = 21;

  req_row_t plan [DIRECTED_REQS] = '{
    // reversed and empty bookings on an empty table
    '{REQ_BOOK, 3'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, STAT_BAD_ORDER},
    '{REQ_BOOK, 3'd7, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, STAT_BAD_ORDER},
    // widest possible interval, then something inside it
    '{REQ_BOOK, 3'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, STAT_STORED},
    '{REQ_BOOK, 3'd0, 32'h0000_0005, 32'h0000_000A, 1'b1, STAT_OVERLAP},
    // top of the time range; touching ends do not clash
    '{REQ_BOOK, 3'd7, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, STAT_STORED},
    '{REQ_BOOK, 3'd7, 32'hFFFF_FFFD, 32'hFFFF_FFFE, 1'b0, STAT_STORED},
    '{REQ_BOOK, 3'd7, 32'hFFFF_FFFD, 32'hFFFF_FFFF, 1'b0, STAT_STORED},
    // reversed load goes in as given and only clashes through the formula
    '{REQ_LOAD, 3'd3, 32'd100,       32'd50,        1'b0, STAT_STORED},
    '{REQ_BOOK, 3'd3, 32'd60,        32'd70,        1'b0, STAT_STORED},
    '{REQ_BOOK, 3'd3, 32'd40,        32'd120,       1'b0, STAT_STORED},
    // unchecked load over an existing booking
    '{REQ_LOAD, 3'd0, 32'd5,         32'd10,        1'b0, STAT_STORED},
    // empty load, then a booking on its start
    '{REQ_LOAD, 3'd5, 32'd0,         32'd0,         1'b0, STAT_STORED},
    '{REQ_BOOK, 3'd5, 32'd0,         32'd1,         1'b0, STAT_STORED},
    // another resource is independent of resource 0
    '{REQ_BOOK, 3'd1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, STAT_STORED},
    // around the top bit of the time fields
    '{REQ_BOOK, 3'd2, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, STAT_STORED},
    '{REQ_BOOK, 3'd2, 32'h8000_0000, 32'h8000_0001, 1'b0, STAT_STORED},
    '{REQ_BOOK, 3'd2, 32'h7FFF_FFFE, 32'h8000_0001, 1'b0, STAT_STORED},
    '{REQ_LOAD, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, STAT_STORED},
    '{REQ_BOOK, 3'd4, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, STAT_BAD_ORDER},
    '{REQ_BOOK, 3'd6, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, STAT_STORED},
    '{REQ_BOOK, 3'd6, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, STAT_STORED}
  };

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic              req_type    = REQ_LOAD;
  logic [RES_W-1:0]  resource_id = '0;
  logic [TIME_W-1:0] start_time  = '0;
  logic [TIME_W-1:0] end_time    = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [1:0]        status;

  // Hand-written expectation travelling with the request currently on the port
  bit      row_typed = 1'b0;
  status_t row_want  = STAT_STORED;

  // Quiet stretches: both sides stop idling for a while
  bit calm = 1'b0;

  // In-bench copy of the reservation table
  logic [RES_W-1:0]  held_res   [SLOTS];
  logic [TIME_W-1:0] held_start [SLOTS];
  logic [TIME_W-1:0] held_end   [SLOTS];
  int                held_count = 0;

  status_t awaited_status [$];

  int errors        = 0;
  int requests_seen = 0;
  int outcome_tally [4] = '{0, 0, 0, 0};
  int quiet_cycles  = 0;

  interval_booking_conflict_table #(
    .ENTRIES(SLOTS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .resource_id(resource_id),
    .start_time (start_time),
    .end_time   (end_time),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status)
  );

  always #6 clk = ~clk;

  // Status of one request against the table, updating the table when it stores.
  // Order: reversed/empty booking, then clash on the same resource, then full.
  function automatic status_t reservation_outcome(logic kind, logic [RES_W-1:0] res,
                                                  logic [TIME_W-1:0] s, logic [TIME_W-1:0] e);
    bit clash = 1'b0;
    if (kind == REQ_BOOK && e <= s) return STAT_BAD_ORDER;
    if (kind == REQ_BOOK) begin
      for (int i = 0; i < held_count; i++) begin
        if (held_res[i] == res && s < held_end[i] && e > held_start[i]) clash = 1'b1;
      end
    end
    if (clash) return STAT_OVERLAP;
    if (held_count >= SLOTS) return STAT_FULL;
    held_res[held_count]   = res;
    held_start[held_count] = s;
    held_end[held_count]   = e;
    held_count++;
    return STAT_STORED;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // Presents one request from a falling edge and holds it until the transfer.
  task automatic send_request(logic kind, logic [RES_W-1:0] res, logic [TIME_W-1:0] s,
                              logic [TIME_W-1:0] e, bit typed, status_t want);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    resource_id <= res;
    start_time  <= s;
    end_time    <= e;
    row_typed   <= typed;
    row_want    <= want;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Request side: every transfer in runs through the table model
  always @(posedge clk) begin
    status_t predicted;
    if (!rst && in_valid && in_ready) begin
      predicted = reservation_outcome(req_type, resource_id, start_time, end_time);
      awaited_status.push_back(row_typed ? row_want : predicted);
      requests_seen++;
    end
  end

  // Result side: compare with the oldest outstanding status
  always @(posedge clk) begin
    status_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_status.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none got %0d", $time, status);
        errors++;
      end else begin
        want = awaited_status.pop_front();
        if (status !== want) begin
          $display("%0t: status mismatch, expected %0d (%s) got %0d",
                   $time, want, want.name(), status);
          errors++;
        end else begin
          outcome_tally[int'(want)]++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, awaited_status.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side back-pressure: a fresh stall before each result
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Stimulus: reset, directed table, random traffic, drain, verdict
  initial begin
    logic              kind;
    logic [RES_W-1:0]  res;
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    logic [TIME_W-1:0] span;
    int                pick;
    int                slot;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_request(plan[i].kind, plan[i].res, plan[i].t_start, plan[i].t_end,
                   plan[i].typed, plan[i].want);
    end

    // Mostly short bookings in a narrow window so clashes are common; the table
    // fills part-way through and the rest exercises the full table, where
    // reversed and clashing bookings still take priority over full.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      calm = (n % 160) < 24;
      pick = $urandom_range(0, 99);
      kind = REQ_BOOK;
      res  = RES_W'($urandom_range(0, 7));
      s    = $urandom_range(0, 2000);
      span = $urandom_range(1, 300);
      e    = s + span;
      if (pick < 6) begin
        // wide load: any bit pattern, reversed half the time
        kind = REQ_LOAD;
        s    = $urandom();
        e    = $urandom();
      end else if (pick < 12) begin
        s = $urandom();
        e = $urandom();
      end else if (pick < 16) begin
        kind = REQ_LOAD;
      end else if (pick < 26) begin
        // empty or reversed booking, unless the end wraps below zero
        e = s - $urandom_range(0, 5);
      end else if (pick < 50 && held_count > 0) begin
        // aim at an edge of something already held on the same resource
        slot = $urandom_range(0, held_count - 1);
        res  = held_res[slot];
        case ($urandom_range(0, 3))
          0: begin
            s = held_end[slot];
            e = s + span;
          end
          1: begin
            e = held_start[slot];
            s = e - span;
          end
          2: begin
            s = held_end[slot] - 1;
            e = s + span;
          end
          default: begin
            s = held_start[slot] - span;
            e = held_start[slot] + 1;
          end
        endcase
      end
      send_request(kind, res, s, e, 1'b0, STAT_STORED);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    calm = 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d from the directed table); %0d of %0d slots held at the end.",
             requests_seen, DIRECTED_REQS, held_count, SLOTS);
    $display("Statuses matched: stored %0d, reversed %0d, clash %0d, full %0d; errors %0d.",
             outcome_tally[0], outcome_tally[1], outcome_tally[2], outcome_tally[3], errors);
    if (errors == 0 && awaited_status.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
